// File: hdl/cfp40_pkg.sv
`default_nettype none
package cfp40_pkg;

  // fixed field geometry
  localparam int unsigned FRAC_W      = 23;
  localparam int unsigned EXP_W       = 8;
  localparam int unsigned MANT_W      = 17;
  localparam int unsigned SHIFT_W     = 5;

  localparam logic [7:0]  OFFSET_RESET = 8'd138;
  localparam logic [9:0]  SHIFT_MIN    = 10'd6;
  localparam logic [4:0]  SHIFT_MAX    = 5'd23;
  localparam logic [3:0]  EXPO_MAX     = 4'hF;
  localparam logic [15:0] MANT_SAT     = 16'hFFFF;

  // stage 1 -> stage 2: exponent compare results
  typedef struct packed {
    logic              sign_r;
    logic              sign_i;
    logic [FRAC_W-1:0] frac_r;
    logic [FRAC_W-1:0] frac_i;
    logic [EXP_W-1:0]  diff_r;   // max exponent minus real exponent
    logic [EXP_W-1:0]  diff_i;
    logic [EXP_W:0]    es_raw;   // two's complement, max exponent minus offset
  } cfp40_s1_t;

  // stage 2 -> stage 3: shift amounts and shared exponent
  typedef struct packed {
    logic               sign_r;
    logic               sign_i;
    logic [FRAC_W-1:0]  frac_r;
    logic [FRAC_W-1:0]  frac_i;
    logic [SHIFT_W-1:0] shift_r;
    logic [SHIFT_W-1:0] shift_i;
    logic [3:0]         expo;
    logic               ovf;
  } cfp40_s2_t;

endpackage
`default_nettype wire

// File: hdl/cfp40_ifs.sv
`default_nettype none
// input channel: one complex value per transaction
interface cfp40_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] real_bits;
  logic [31:0] imag_bits;
  modport source (output valid, output real_bits, output imag_bits, input ready);
  modport sink   (input valid, input real_bits, input imag_bits, output ready);
endinterface

// result channel: one packed record per transaction
interface cfp40_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  header_byte;
  logic [15:0] real_mantissa_low;
  logic [15:0] imag_mantissa_low;
  modport source (output valid, output header_byte, output real_mantissa_low,
                  output imag_mantissa_low, input ready);
  modport sink   (input valid, input header_byte, input real_mantissa_low,
                  input imag_mantissa_low, output ready);
endinterface

// configuration write channel
interface cfp40_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] exponent_offset;
  modport source (output valid, output exponent_offset, input ready);
  modport sink   (input valid, input exponent_offset, output ready);
endinterface
`default_nettype wire

// File: hdl/cfp40_expo.sv
`default_nettype none
module cfp40_expo
  import cfp40_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  offset,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire logic [31:0] real_bits,
  input  wire logic [31:0] imag_bits,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output cfp40_s2_t        dn_data
);

  logic      v1_r, v2_r;
  cfp40_s1_t s1_r, s1_nxt;
  cfp40_s2_t s2_r, s2_nxt;
  logic      rdy1, rdy2;

  // per-stage ready: a stage moves when it is empty or its successor takes it
  assign rdy2     = !v2_r || dn_ready;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v2_r;
  assign dn_data  = s2_r;

  // stage 1: larger exponent, differences, shared exponent before clamping
  always_comb begin
    logic [EXP_W-1:0] exp_r, exp_i, emax;
    exp_r = real_bits[30:23];
    exp_i = imag_bits[30:23];
    emax  = (exp_r > exp_i) ? exp_r : exp_i;
    s1_nxt.sign_r = real_bits[31];
    s1_nxt.sign_i = imag_bits[31];
    s1_nxt.frac_r = real_bits[FRAC_W-1:0];
    s1_nxt.frac_i = imag_bits[FRAC_W-1:0];
    s1_nxt.diff_r = emax - exp_r;
    s1_nxt.diff_i = emax - exp_i;
    s1_nxt.es_raw = {1'b0, emax} - {1'b0, offset};
  end

  // stage 2: total shifts with saturation, clamp shared exponent
  always_comb begin
    logic             neg;
    logic [EXP_W-1:0] mag;
    logic [9:0]       tot_r, tot_i;
    neg   = s1_r.es_raw[EXP_W];
    mag   = neg ? (~s1_r.es_raw[EXP_W-1:0] + 8'd1) : 8'd0;
    tot_r = SHIFT_MIN + {2'b00, s1_r.diff_r} + {2'b00, mag};
    tot_i = SHIFT_MIN + {2'b00, s1_r.diff_i} + {2'b00, mag};
    s2_nxt.sign_r  = s1_r.sign_r;
    s2_nxt.sign_i  = s1_r.sign_i;
    s2_nxt.frac_r  = s1_r.frac_r;
    s2_nxt.frac_i  = s1_r.frac_i;
    s2_nxt.shift_r = (tot_r > {5'd0, SHIFT_MAX}) ? SHIFT_MAX : tot_r[SHIFT_W-1:0];
    s2_nxt.shift_i = (tot_i > {5'd0, SHIFT_MAX}) ? SHIFT_MAX : tot_i[SHIFT_W-1:0];
    s2_nxt.ovf     = !neg && (s1_r.es_raw[EXP_W-1:0] > {4'd0, EXPO_MAX});
    if (neg) begin
      s2_nxt.expo = 4'd0;
    end else if (s2_nxt.ovf) begin
      s2_nxt.expo = EXPO_MAX;
    end else begin
      s2_nxt.expo = s1_r.es_raw[3:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r)     s2_r <= s2_nxt;
  end

`ifndef ASSERT_OFF
  // every shift keeps the floor of six
  a_shift_floor: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (s2_r.shift_r >= 5'd6 && s2_r.shift_i >= 5'd6))
    else $error("shift below floor");
  // on overflow the shared exponent is positive, so the larger part shifts by the floor
  a_ovf_min_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && s2_r.ovf) |-> (s2_r.shift_r == 5'd6 || s2_r.shift_i == 5'd6))
    else $error("overflow without minimal shift");
`endif

endmodule
`default_nettype wire

// File: hdl/cfp40_mant.sv
`default_nettype none
module cfp40_mant
  import cfp40_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  cfp40_s2_t  up_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0]  header_byte,
  output logic [15:0] real_mantissa_low,
  output logic [15:0] imag_mantissa_low
);

  logic        v3_r;
  logic [7:0]  hdr_r, hdr_nxt;
  logic [15:0] mr_r, mr_nxt, mi_r, mi_nxt;
  logic        rdy3;

  // shift, round unless zero or all ones, set flag, halve
  function automatic logic [MANT_W-1:0] pack_part(input logic [FRAC_W-1:0] frac,
                                                  input logic [SHIFT_W-1:0] s);
    logic [FRAC_W-1:0] m;
    logic [FRAC_W-1:0] ones;
    logic [FRAC_W:0]   mf;
    m    = frac >> s;
    ones = {FRAC_W{1'b1}} >> s;
    if (m != '0 && m != ones) m = m + 23'd1;
    mf   = {1'b0, m} | (24'd1 << (SHIFT_MAX - s));
    return mf[MANT_W:1];
  endfunction

  assign rdy3      = !v3_r || out_ready;
  assign up_ready  = rdy3;
  assign out_valid = v3_r;

  // stage 3: mantissas and header
  always_comb begin
    logic [MANT_W-1:0] pr, pi;
    pr = pack_part(up_data.frac_r, up_data.shift_r);
    pi = pack_part(up_data.frac_i, up_data.shift_i);
    if (up_data.ovf) begin
      pr = {1'b0, MANT_SAT};
      pi = {1'b0, MANT_SAT};
    end
    mr_nxt  = pr[15:0];
    mi_nxt  = pi[15:0];
    hdr_nxt = {up_data.sign_r, up_data.sign_i, pr[16], pi[16], up_data.expo};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= up_valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rdy3 && up_valid) begin
      hdr_r <= hdr_nxt;
      mr_r  <= mr_nxt;
      mi_r  <= mi_nxt;
    end
  end

  assign header_byte       = hdr_r;
  assign real_mantissa_low = mr_r;
  assign imag_mantissa_low = mi_r;

`ifndef ASSERT_OFF
  // a fully shifted-out real part leaves a zero mantissa
  a_real_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (up_valid && rdy3 && up_data.shift_r == SHIFT_MAX && !up_data.ovf)
      |=> (real_mantissa_low == 16'd0 && header_byte[5] == 1'b0))
    else $error("real mantissa not zero at full shift");
  // same for the imaginary part
  a_imag_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (up_valid && rdy3 && up_data.shift_i == SHIFT_MAX && !up_data.ovf)
      |=> (imag_mantissa_low == 16'd0 && header_byte[4] == 1'b0))
    else $error("imag mantissa not zero at full shift");
`endif

endmodule
`default_nettype wire

// File: hdl/complex_float_to_packed40.sv
// An accepted input reaches out_ch through the stage 1, stage 2 and output registers.
// Throughput: one transaction per cycle while out_ch.ready holds; three register stages
// (exponent compare, shift computation, mantissa round and pack), each with its own valid bit.
// Empty stages keep filling while a result waits at the output register.
// Reset (rst_n, synchronous, active low) clears all valid bits and loads
// exponent_offset with 138; data registers are not reset.
`default_nettype none
module complex_float_to_packed40
  import cfp40_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  cfp40_cfg_if.sink  cfg_ch,
  cfp40_in_if.sink   in_ch,
  cfp40_out_if.source out_ch
);

  logic [7:0] offset_r;
  logic       mid_valid, mid_ready;
  cfp40_s2_t  mid_data;

  // configuration register, always writable
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
    end else if (cfg_ch.valid) begin
      offset_r <= cfg_ch.exponent_offset;
    end
  end

  // exponent stages
  cfp40_expo u_expo (
    .clk       (clk),
    .rst_n     (rst_n),
    .offset    (offset_r),
    .up_valid  (in_ch.valid),
    .up_ready  (in_ch.ready),
    .real_bits (in_ch.real_bits),
    .imag_bits (in_ch.imag_bits),
    .dn_valid  (mid_valid),
    .dn_ready  (mid_ready),
    .dn_data   (mid_data)
  );

  // mantissa stage and output register
  cfp40_mant u_mant (
    .clk               (clk),
    .rst_n             (rst_n),
    .up_valid          (mid_valid),
    .up_ready          (mid_ready),
    .up_data           (mid_data),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .header_byte       (out_ch.header_byte),
    .real_mantissa_low (out_ch.real_mantissa_low),
    .imag_mantissa_low (out_ch.imag_mantissa_low)
  );

endmodule
`default_nettype wire
